// ===== src/rtpa_pkg.sv =====
// rtpa_pkg: shared types and codes for the region table page allocator
// no dependencies
package rtpa_pkg;

  typedef enum logic [1:0] {
    KIND_UNUSED = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_ALLOC  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADIDX  = 2'd2,
    ST_NOTALLOC = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_LOOKUP  = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_COAL,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic init;       // rebuild table from pool registers
    logic load;       // capture input item
    logic scan_clr;   // reset search pointers
    logic scan_step;  // examine one entry during alloc search
    logic alloc_do;   // commit allocation
    logic rel_mark;   // mark released entry free
    logic coal_clr;   // reset pair counters
    logic coal_step;  // examine one coalescing pair
    logic res_load;   // compute result
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;
    logic coal_last;
    logic is_alloc;
    logic is_release;
    logic rel_ok;
  } ctl_sts_t;

endpackage

// ===== src/rtpa_ctrl.sv =====
// rtpa_ctrl: sequencing state machine for the allocator
// depends on rtpa_pkg
module rtpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_we,
  input  rtpa_pkg::ctl_sts_t  sts,
  output rtpa_pkg::ctl_cmd_t  cmd
);

  rtpa_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtpa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd.init = cfg_we;
    unique case (state)
      rtpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = rtpa_pkg::S_SCAN;
        end
      end
      rtpa_pkg::S_SCAN: begin
        if (sts.is_alloc) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) state_next = rtpa_pkg::S_DECIDE;
        end else begin
          state_next = rtpa_pkg::S_DECIDE;
        end
      end
      rtpa_pkg::S_DECIDE: begin
        cmd.res_load = 1'b1;
        cmd.alloc_do = sts.is_alloc;
        cmd.coal_clr = 1'b1;
        if (sts.is_release && sts.rel_ok) begin
          cmd.rel_mark = 1'b1;
          state_next = rtpa_pkg::S_COAL;
        end else begin
          state_next = rtpa_pkg::S_DONE;
        end
      end
      rtpa_pkg::S_COAL: begin
        cmd.coal_step = 1'b1;
        if (sts.coal_last) state_next = rtpa_pkg::S_DONE;
      end
      rtpa_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = rtpa_pkg::S_IDLE;
      end
      default: state_next = rtpa_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== src/rtpa_dpath.sv =====
// rtpa_dpath: region table, search pointers and result registers
// depends on rtpa_pkg
module rtpa_dpath #(
  parameter int TABLE_DEPTH = 16,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [1:0]          action,
  input  logic [19:0]         pages_wanted,
  input  logic [7:0]          region_index,
  input  rtpa_pkg::ctl_cmd_t  cmd,
  output rtpa_pkg::ctl_sts_t  sts,
  output logic [1:0]          status,
  output logic [3:0]          granted_index,
  output logic [31:0]         address
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = IW + 1;

  logic [31:0] pool_start, pool_end;
  logic [31:0] ent_start [TABLE_DEPTH];
  logic [31:0] ent_size  [TABLE_DEPTH];
  rtpa_pkg::kind_t ent_kind [TABLE_DEPTH];

  rtpa_pkg::action_t act;
  logic [7:0]  idx;
  logic [51:0] need;
  logic [IW-1:0] scan_i, fit_i, free_i;
  logic fit_found, free_found;
  logic [IW-1:0] ci, cj;
  logic [32:0] sum_ij;
  logic idx_ok;
  logic [IW-1:0] idx_s;
  logic [31:0] new_start, fit_rem;

  // pool registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_start <= '0;
      pool_end   <= '0;
    end else if (cfg_we) begin
      if (cfg_index) pool_end <= cfg_data;
      else pool_start <= cfg_data;
    end
  end

  // captured item; need computed at capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= rtpa_pkg::action_t'(action);
      idx  <= region_index;
      need <= {32'd0, pages_wanted} * 52'(PAGE_BYTES);
    end
  end

  assign idx_ok = ({24'd0, idx} < 32'(TABLE_DEPTH));
  assign idx_s  = idx[IW-1:0];
  assign sts.is_alloc   = (act == rtpa_pkg::ACT_ALLOC);
  assign sts.is_release = (act == rtpa_pkg::ACT_RELEASE);
  assign sts.rel_ok     = idx_ok && (ent_kind[idx_s] == rtpa_pkg::KIND_ALLOC);
  assign sts.scan_last  = (scan_i == IW'(TABLE_DEPTH - 1));
  assign sts.coal_last  = (ci == IW'(TABLE_DEPTH - 1)) && (cj == IW'(TABLE_DEPTH - 1));
  assign sum_ij   = {1'b0, ent_start[ci]} + {1'b0, ent_size[ci]};
  assign new_start = ent_start[fit_i] + need[31:0];
  assign fit_rem   = ent_size[fit_i] - need[31:0];

  // search and pair counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_i <= '0; fit_found <= 1'b0; free_found <= 1'b0;
      fit_i <= '0; free_i <= '0; ci <= '0; cj <= '0;
    end else begin
      if (cmd.scan_clr) begin
        scan_i <= '0; fit_found <= 1'b0; free_found <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_i <= scan_i + IW'(1);
        if (!fit_found && ent_kind[scan_i] == rtpa_pkg::KIND_FREE &&
            {20'd0, ent_size[scan_i]} >= need) begin
          fit_found <= 1'b1; fit_i <= scan_i;
        end
        if (!free_found && ent_kind[scan_i] == rtpa_pkg::KIND_UNUSED) begin
          free_found <= 1'b1; free_i <= scan_i;
        end
      end
      if (cmd.coal_clr) begin
        ci <= '0; cj <= '0;
      end else if (cmd.coal_step) begin
        if (cj == IW'(TABLE_DEPTH - 1)) begin
          cj <= '0;
          ci <= ci + IW'(1);
        end else begin
          cj <= cj + IW'(1);
        end
      end
    end
  end

  logic alloc_ok;
  assign alloc_ok = fit_found && free_found && (need[51:32] == '0);

  // region table
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        ent_start[k] <= '0; ent_size[k] <= '0; ent_kind[k] <= rtpa_pkg::KIND_UNUSED;
      end
      if (rst) begin
        ent_kind[0] <= rtpa_pkg::KIND_FREE;
      end else begin
        ent_start[0] <= cfg_index ? pool_start : cfg_data;
        ent_size[0]  <= cfg_index ? ((cfg_data >= pool_start) ? cfg_data - pool_start : '0)
                                  : ((pool_end >= cfg_data) ? pool_end - cfg_data : '0);
        ent_kind[0]  <= rtpa_pkg::KIND_FREE;
      end
    end else begin
      if (cmd.alloc_do && alloc_ok) begin
        ent_start[free_i] <= ent_start[fit_i];
        ent_size[free_i]  <= need[31:0];
        ent_kind[free_i]  <= rtpa_pkg::KIND_ALLOC;
        ent_size[fit_i]   <= fit_rem;
        if (fit_rem == '0) begin
          ent_start[fit_i] <= '0;
          ent_kind[fit_i]  <= rtpa_pkg::KIND_UNUSED;
        end else begin
          ent_start[fit_i] <= new_start;
        end
      end
      if (cmd.rel_mark) ent_kind[idx_s] <= rtpa_pkg::KIND_FREE;
      // one pair per cycle: free ci absorbs adjacent free cj
      if (cmd.coal_step && ci != cj && ent_kind[ci] == rtpa_pkg::KIND_FREE &&
          ent_kind[cj] == rtpa_pkg::KIND_FREE && sum_ij == {1'b0, ent_start[cj]}) begin
        ent_size[ci]  <= ent_size[ci] + ent_size[cj];
        ent_start[cj] <= '0;
        ent_size[cj]  <= '0;
        ent_kind[cj]  <= rtpa_pkg::KIND_UNUSED;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= rtpa_pkg::ST_OK;
      granted_index <= '0;
      address <= '0;
      unique case (act)
        rtpa_pkg::ACT_ALLOC: begin
          if (alloc_ok) begin
            granted_index <= 4'(free_i);
            address <= ent_start[fit_i];
          end else begin
            status <= rtpa_pkg::ST_NOMEM;
          end
        end
        rtpa_pkg::ACT_RELEASE, rtpa_pkg::ACT_LOOKUP: begin
          if (!idx_ok) status <= rtpa_pkg::ST_BADIDX;
          else if (ent_kind[idx_s] != rtpa_pkg::KIND_ALLOC) status <= rtpa_pkg::ST_NOTALLOC;
          else if (act == rtpa_pkg::ACT_LOOKUP) address <= ent_start[idx_s];
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/region_table_page_allocator_unit.sv =====
// region table page allocator: first-fit allocate, release with coalescing, lookup
// steps: allocate searches the table one entry per cycle; a valid release then coalesces
// one pair per cycle over all TABLE_DEPTH*TABLE_DEPTH pairs; lookup does no search
// throughput: one item at a time; next item accepted after the result transfer
// reset: synchronous rst clears pool registers; entry 0 free with length 0
module region_table_page_allocator_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [19:0] pages_wanted,
  input  logic [7:0]  region_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  granted_index,
  output logic [31:0] address,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  rtpa_pkg::ctl_cmd_t cmd;
  rtpa_pkg::ctl_sts_t sts;

  // controller
  rtpa_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cfg_we,
    .sts, .cmd
  );

  // datapath
  rtpa_dpath #(.TABLE_DEPTH(TABLE_DEPTH), .PAGE_BYTES(PAGE_BYTES)) u_dpath (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .action, .pages_wanted,
    .region_index, .cmd, .sts, .status, .granted_index, .address
  );

endmodule

// ===== sim/tb_region_table_page_allocator_unit.sv =====
// testbench for region_table_page_allocator_unit: first-fit alloc, release, lookup
// depends on rtpa_pkg and the unit; predicts every result and checks it in order
`timescale 1ns / 100ps

module tb_region_table_page_allocator_unit;

  localparam int DEPTH = 16;
  localparam int PAGE = 4096;
  localparam logic REG_POOL_START = 1'b0;
  localparam logic REG_POOL_END = 1'b1;

  typedef struct packed {
    rtpa_pkg::status_t st;
    logic [3:0] gidx;
    logic [31:0] addr;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = '0;
  logic [19:0] pages_wanted = '0;
  logic [7:0] region_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [3:0] granted_index;
  logic [31:0] address;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  // shadow table and pool registers
  logic [31:0] sh_start [DEPTH];
  logic [31:0] sh_size [DEPTH];
  rtpa_pkg::kind_t sh_kind [DEPTH];
  logic [31:0] sh_pool_start, sh_pool_end;

  alloc_result_t expected_q [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  region_table_page_allocator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .pages_wanted(pages_wanted), .region_index(region_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .granted_index(granted_index), .address(address),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  // rebuild shadow table from the pool registers
  function automatic void table_rebuild();
    for (int i = 0; i < DEPTH; i++) begin
      sh_start[i] = '0;
      sh_size[i] = '0;
      sh_kind[i] = rtpa_pkg::KIND_UNUSED;
    end
    sh_start[0] = sh_pool_start;
    sh_size[0] = (sh_pool_end >= sh_pool_start) ? sh_pool_end - sh_pool_start : '0;
    sh_kind[0] = rtpa_pkg::KIND_FREE;
  endfunction

  // merge each free region with free regions starting at its end
  function automatic void coalesce_shadow();
    for (int i = 0; i < DEPTH; i++) begin
      if (sh_kind[i] != rtpa_pkg::KIND_FREE) continue;
      for (int j = 0; j < DEPTH; j++) begin
        if (i == j || sh_kind[j] != rtpa_pkg::KIND_FREE) continue;
        if ({1'b0, sh_start[i]} + {1'b0, sh_size[i]} == {1'b0, sh_start[j]}) begin
          sh_size[i] = sh_size[i] + sh_size[j];
          sh_start[j] = '0;
          sh_size[j] = '0;
          sh_kind[j] = rtpa_pkg::KIND_UNUSED;
        end
      end
    end
  endfunction

  function automatic alloc_result_t predict_region_op(logic [1:0] act, logic [19:0] pg,
                                                      logic [7:0] idx);
    alloc_result_t r;
    logic [51:0] need;
    int fi, ni;
    r = '{st: rtpa_pkg::ST_OK, gidx: '0, addr: '0};
    fi = -1;
    ni = -1;
    if (act == rtpa_pkg::ACT_ALLOC) begin
      need = 52'(pg) * PAGE;
      if (need <= 52'hFFFF_FFFF) begin
        for (int i = 0; i < DEPTH; i++)
          if (fi < 0 && sh_kind[i] == rtpa_pkg::KIND_FREE && 52'(sh_size[i]) >= need)
            fi = i;
        for (int i = 0; i < DEPTH; i++)
          if (ni < 0 && sh_kind[i] == rtpa_pkg::KIND_UNUSED) ni = i;
      end
      if (fi < 0 || ni < 0) begin
        r.st = rtpa_pkg::ST_NOMEM;
      end else begin
        r.addr = sh_start[fi];
        sh_start[ni] = r.addr;
        sh_size[ni] = need[31:0];
        sh_kind[ni] = rtpa_pkg::KIND_ALLOC;
        sh_start[fi] = r.addr + need[31:0];
        sh_size[fi] = sh_size[fi] - need[31:0];
        if (sh_size[fi] == 0) begin
          sh_start[fi] = '0;
          sh_kind[fi] = rtpa_pkg::KIND_UNUSED;
        end
        r.gidx = 4'(ni);
      end
    end else if (act == rtpa_pkg::ACT_RELEASE || act == rtpa_pkg::ACT_LOOKUP) begin
      if (idx >= DEPTH) begin
        r.st = rtpa_pkg::ST_BADIDX;
      end else if (sh_kind[idx] != rtpa_pkg::KIND_ALLOC) begin
        r.st = rtpa_pkg::ST_NOTALLOC;
      end else if (act == rtpa_pkg::ACT_RELEASE) begin
        sh_kind[idx] = rtpa_pkg::KIND_FREE;
        coalesce_shadow();
      end else begin
        r.addr = sh_start[idx];
      end
    end
    return r;
  endfunction

  // receiver: random stall, compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result st=%0d gi=%0d addr=%h", $time, status,
                   granted_index, address);
        end else begin
          exp_r = expected_q.pop_front();
          if (status !== exp_r.st) begin
            errors++;
            $display("%0t status exp %0d got %0d", $time, exp_r.st, status);
          end
          if (granted_index !== exp_r.gidx) begin
            errors++;
            $display("%0t granted_index exp %0d got %0d", $time, exp_r.gidx, granted_index);
          end
          if (address !== exp_r.addr) begin
            errors++;
            $display("%0t address exp %h got %h", $time, exp_r.addr, address);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one input transfer; returns at the edge that follows the accepting edge
  task automatic send_item(logic [1:0] act, logic [19:0] pg, logic [7:0] idx);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    expected_q.push_back(predict_region_op(act, pg, idx));
    in_valid <= 1'b1;
    action <= act;
    pages_wanted <= pg;
    region_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DEPTH * DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic ri, logic [31:0] v);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_index <= ri;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (ri == REG_POOL_START) sh_pool_start = v;
    else sh_pool_end = v;
    table_rebuild();
  endtask

  task automatic set_pool(logic [31:0] s, logic [31:0] e);
    write_reg(REG_POOL_START, s);
    write_reg(REG_POOL_END, e);
  endtask

  // extremes of every field and each special case
  task automatic test_directed();
    send_item(rtpa_pkg::ACT_ALLOC, 20'd0, 8'd0);
    send_item(rtpa_pkg::ACT_NOP, 20'hFFFFF, 8'hFF);
    set_pool(32'h0000_1000, 32'h0000_0800);
    send_item(rtpa_pkg::ACT_ALLOC, 20'd0, 8'd0);
    set_pool(32'h0010_0000, 32'h0020_0000);
    send_item(rtpa_pkg::ACT_ALLOC, 20'hFFFFF, 8'd0);
    send_item(rtpa_pkg::ACT_ALLOC, 20'd1, 8'd0);
    send_item(rtpa_pkg::ACT_ALLOC, 20'd2, 8'd0);
    send_item(rtpa_pkg::ACT_ALLOC, 20'd0, 8'd0);
    send_item(rtpa_pkg::ACT_LOOKUP, 20'd0, 8'd1);
    send_item(rtpa_pkg::ACT_LOOKUP, 20'd0, 8'd0);
    send_item(rtpa_pkg::ACT_LOOKUP, 20'd0, 8'd16);
    send_item(rtpa_pkg::ACT_RELEASE, 20'd0, 8'd255);
    send_item(rtpa_pkg::ACT_RELEASE, 20'd0, 8'd15);
    send_item(rtpa_pkg::ACT_RELEASE, 20'd0, 8'd2);
    send_item(rtpa_pkg::ACT_RELEASE, 20'd0, 8'd1);
    send_item(rtpa_pkg::ACT_RELEASE, 20'd1, 8'd1);
    send_item(rtpa_pkg::ACT_ALLOC, 20'd256, 8'd0);
    for (int i = 0; i < 17; i++) send_item(rtpa_pkg::ACT_ALLOC, 20'd0, 8'd0);
    // largest pool, exact fit empties the free region
    set_pool(32'h0000_0000, 32'hFFFF_F000);
    send_item(rtpa_pkg::ACT_ALLOC, 20'hFFFFF, 8'd0);
    send_item(rtpa_pkg::ACT_ALLOC, 20'd0, 8'd0);
    send_item(rtpa_pkg::ACT_RELEASE, 20'd0, 8'd1);
    set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(rtpa_pkg::ACT_ALLOC, 20'd0, 8'd0);
  endtask

  // mostly alloc/release churn aimed at live slots, with some noise
  task automatic test_random(int n);
    logic [19:0] pg;
    logic [7:0] idx;
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      pg = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(6));
      idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(DEPTH - 1));
      if (sel < 45) send_item(rtpa_pkg::ACT_ALLOC, pg, 8'($urandom));
      else if (sel < 80) send_item(rtpa_pkg::ACT_RELEASE, 20'($urandom), idx);
      else if (sel < 97) send_item(rtpa_pkg::ACT_LOOKUP, 20'($urandom), idx);
      else send_item(rtpa_pkg::ACT_NOP, 20'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    sh_pool_start = '0;
    sh_pool_end = '0;
    table_rebuild();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 51;
    test_directed();

    set_pool(32'h8000_0000, 32'h8002_0000);
    test_random(400);
    // hold off until all results are back
    wait_drain();

    send_idle_pct = 51;
    recv_idle_pct = 7;
    set_pool(32'($urandom) & 32'hFFFF_F000, 32'hFFFF_FFFF);
    test_random(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_pool(32'h0000_0000, 32'h0000_8000);
    test_random(400);

    wait_drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== region_table_page_allocator_unit.f =====
src/rtpa_pkg.sv
src/rtpa_ctrl.sv
src/rtpa_dpath.sv
src/region_table_page_allocator_unit.sv
sim/tb_region_table_page_allocator_unit.sv
